// ===== rtl/rsfr_pkg.sv =====
// ----------------------------------------------------------------------------
// RS485 frame receiver package
// Shared types, register indexes and codes for the frame receiver block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsfr_pkg;

	localparam int TIMER_W    = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int BYTE_W     = 8;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_RX_TIMEOUT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LINK_HOLD    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RECONNECT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_LINK   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_FIRST   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_SECOND  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_FIRST   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_SECOND  = 3'd7;

	// Register reset values.
	localparam logic [TIMER_W-1:0] RX_TIMEOUT_RST = 17'd500;
	localparam logic [TIMER_W-1:0] LINK_HOLD_RST  = 17'd20000;
	localparam logic [TIMER_W-1:0] RECONNECT_RST  = 17'd60000;
	localparam logic [TIMER_W-1:0] FIRST_LINK_RST = 17'd100000;
	localparam logic [BYTE_W-1:0]  HEAD_FIRST_RST  = 8'd85;
	localparam logic [BYTE_W-1:0]  HEAD_SECOND_RST = 8'd170;
	localparam logic [BYTE_W-1:0]  TAIL_FIRST_RST  = 8'd13;
	localparam logic [BYTE_W-1:0]  TAIL_SECOND_RST = 8'd10;

	// Request kinds carried on tuser.
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Per-byte outcome codes.
	localparam logic [1:0] OUT_STORED     = 2'd0;
	localparam logic [1:0] OUT_FORWARDED  = 2'd1;
	localparam logic [1:0] OUT_SUPPRESSED = 2'd2;
	localparam logic [1:0] OUT_OVERLONG   = 2'd3;

	// Keep-alive signature at frame positions 2 to 4.
	localparam logic [BYTE_W-1:0] KA_C = 8'h63;
	localparam logic [BYTE_W-1:0] KA_N = 8'h6e;
	localparam logic [BYTE_W-1:0] KA_T = 8'h74;

	typedef struct packed {
		logic [TIMER_W-1:0] rx_timeout_ticks;
		logic [TIMER_W-1:0] link_hold_ticks;
		logic [TIMER_W-1:0] reconnect_ticks;
		logic [BYTE_W-1:0]  head_first;
		logic [BYTE_W-1:0]  head_second;
		logic [BYTE_W-1:0]  tail_first;
		logic [BYTE_W-1:0]  tail_second;
	} cfg_t;

	typedef struct packed {
		logic              disconnect_notice;
		logic              rx_timeout_hit;
		logic [BYTE_W-1:0] frame_length;
		logic [1:0]        byte_outcome;
		logic [BYTE_W-1:0] byte_position;
		logic [BYTE_W-1:0] echo_byte;
	} res_t;

	localparam int RES_W   = $bits(res_t);
	localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== rtl/rsfr_cfg.sv =====
// ----------------------------------------------------------------------------
// RS485 frame receiver configuration registers
// Holds the timer reloads and the head and tail bytes written over the port.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfr_cfg
	import rsfr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	// The first link period only matters at reset, so its register is not kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rx_timeout_ticks <= RX_TIMEOUT_RST;
			cfg_q.link_hold_ticks  <= LINK_HOLD_RST;
			cfg_q.reconnect_ticks  <= RECONNECT_RST;
			cfg_q.head_first       <= HEAD_FIRST_RST;
			cfg_q.head_second      <= HEAD_SECOND_RST;
			cfg_q.tail_first       <= TAIL_FIRST_RST;
			cfg_q.tail_second      <= TAIL_SECOND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RX_TIMEOUT:  cfg_q.rx_timeout_ticks <= cfg_data;
				REG_LINK_HOLD:   cfg_q.link_hold_ticks  <= cfg_data;
				REG_RECONNECT:   cfg_q.reconnect_ticks  <= cfg_data;
				REG_HEAD_FIRST:  cfg_q.head_first       <= cfg_data[BYTE_W-1:0];
				REG_HEAD_SECOND: cfg_q.head_second      <= cfg_data[BYTE_W-1:0];
				REG_TAIL_FIRST:  cfg_q.tail_first       <= cfg_data[BYTE_W-1:0];
				REG_TAIL_SECOND: cfg_q.tail_second      <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/rsfr_frame.sv =====
// ----------------------------------------------------------------------------
// RS485 frame receiver framing and timers
// Frame state, receive and link timers, keep-alive thinning; one request per
// cycle when accepted; result formed combinationally from the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfr_frame
	import rsfr_pkg::*;
#(
	parameter int MAX_FRAME        = 200,
	parameter int KEEPALIVE_RELOAD = 6
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  cfg_t                   cfg,
	input  wire logic              req_accept,
	input  wire logic              req_type,
	input  wire logic [BYTE_W-1:0] rx_byte,
	output res_t                   res
);

	localparam logic [BYTE_W:0] MAX_FRAME_C = (BYTE_W+1)'(MAX_FRAME);
	localparam logic [3:0]      KA_RELOAD_C = 4'(KEEPALIVE_RELOAD);
	localparam logic [BYTE_W:0] MIN_LEN_C   = (BYTE_W+1)'(6);

	logic [BYTE_W-1:0]  frame_count_q;
	logic [1:0]         head_flags_q;
	logic [2:0]         ka_match_q;
	logic [BYTE_W-1:0]  prev_byte_q;
	logic [TIMER_W-1:0] rx_timer_q;
	logic               rx_active_q;
	logic [TIMER_W-1:0] link_timer_q;
	logic [3:0]         ka_count_q;

	logic [BYTE_W-1:0]  frame_count_d;
	logic [1:0]         head_flags_d;
	logic [2:0]         ka_match_d;
	logic [TIMER_W-1:0] rx_timer_d;
	logic               rx_active_d;
	logic [TIMER_W-1:0] link_timer_d;
	logic [3:0]         ka_count_d;

	logic [BYTE_W:0]    count;
	logic               overlong;
	logic               complete;
	logic [TIMER_W-1:0] rx_dec;
	logic [TIMER_W-1:0] link_dec;
	logic               rx_expire;
	logic               link_expire;

	always_comb begin
		count    = {1'b0, frame_count_q} + (BYTE_W+1)'(1);
		overlong = (count >= MAX_FRAME_C);
		complete = (count > MIN_LEN_C) && (head_flags_q == 2'b11)
			&& (prev_byte_q == cfg.tail_first) && (rx_byte == cfg.tail_second);

		rx_dec      = (rx_timer_q != '0) ? rx_timer_q - TIMER_W'(1) : rx_timer_q;
		link_dec    = (link_timer_q != '0) ? link_timer_q - TIMER_W'(1) : link_timer_q;
		rx_expire   = rx_active_q && (rx_dec == '0);
		link_expire = (link_dec == '0);

		frame_count_d = frame_count_q;
		head_flags_d  = head_flags_q;
		ka_match_d    = ka_match_q;
		rx_timer_d    = rx_timer_q;
		rx_active_d   = rx_active_q;
		link_timer_d  = link_timer_q;
		ka_count_d    = ka_count_q;
		res           = '0;

		if (req_type == REQ_BYTE) begin
			res.echo_byte     = rx_byte;
			res.byte_position = frame_count_q;
			frame_count_d     = count[BYTE_W-1:0];
			case (frame_count_q)
				8'd0: begin
					rx_timer_d      = cfg.rx_timeout_ticks;
					rx_active_d     = 1'b1;
					link_timer_d    = cfg.link_hold_ticks;
					head_flags_d[0] = (rx_byte == cfg.head_first);
				end
				8'd1: head_flags_d[1] = (rx_byte == cfg.head_second);
				8'd2: ka_match_d[0] = (rx_byte == KA_C);
				8'd3: ka_match_d[1] = (rx_byte == KA_N);
				8'd4: ka_match_d[2] = (rx_byte == KA_T);
				default: ;
			endcase
			if (overlong) begin
				frame_count_d    = '0;
				rx_active_d      = 1'b0;
				link_timer_d     = cfg.link_hold_ticks;
				res.byte_outcome = OUT_OVERLONG;
			end else if (complete) begin
				frame_count_d    = '0;
				rx_active_d      = 1'b0;
				link_timer_d     = cfg.link_hold_ticks;
				res.frame_length = count[BYTE_W-1:0];
				res.byte_outcome = OUT_FORWARDED;
				if (ka_match_q == 3'b111) begin
					if (ka_count_q[3]) begin
						ka_count_d = KA_RELOAD_C;
					end else begin
						ka_count_d       = ka_count_q - 4'd1;
						res.byte_outcome = OUT_SUPPRESSED;
					end
				end
			end
		end else begin
			if (rx_active_q) begin
				rx_timer_d = rx_dec;
			end
			if (rx_expire) begin
				frame_count_d      = '0;
				rx_active_d        = 1'b0;
				res.rx_timeout_hit = 1'b1;
			end
			link_timer_d = link_dec;
			if (link_expire) begin
				ka_count_d            = '0;
				link_timer_d          = cfg.reconnect_ticks;
				res.disconnect_notice = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			head_flags_q  <= '0;
			ka_match_q    <= '0;
			prev_byte_q   <= '0;
			rx_timer_q    <= '0;
			rx_active_q   <= 1'b0;
			link_timer_q  <= FIRST_LINK_RST;
			ka_count_q    <= '0;
		end else if (req_accept) begin
			frame_count_q <= frame_count_d;
			head_flags_q  <= head_flags_d;
			ka_match_q    <= ka_match_d;
			rx_timer_q    <= rx_timer_d;
			rx_active_q   <= rx_active_d;
			link_timer_q  <= link_timer_d;
			ka_count_q    <= ka_count_d;
			if (req_type == REQ_BYTE) begin
				prev_byte_q <= rx_byte;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rsfr_skid.sv =====
// ----------------------------------------------------------------------------
// RS485 frame receiver output stage
// Output register with a skid entry, so the ready toward the source is
// registered and a new request is taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfr_skid
	import rsfr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  res_t      in_res,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_res
);

	logic out_valid_q;
	logic skid_valid_q;
	res_t out_q;
	res_t skid_q;
	logic take;
	logic load_out;

	assign take     = in_valid && !skid_valid_q;
	assign load_out = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q  <= skid_valid_q || take;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_valid_q ? skid_q : in_res;
		end else if (take) begin
			skid_q <= in_res;
		end
	end

	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule

`default_nettype wire

// ===== rtl/rs485_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// RS485 frame receiver core
// Frames received bytes, checks head and tail, thins keep-alives and runs the
// receive and link timers.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel: tuser low carries a received byte in
// tdata[7:0], tuser high is one timebase tick. Every request gives exactly one
// result on the m_axis channel, in order.
// A request is taken in every cycle while s_axis_tready is high; the framing
// and timer update is one combinational pass from the frame state to the
// output register, or to the skid entry while the output is stalled.
// Sustained throughput is one request per cycle as long as the sink keeps
// m_axis_tready high. When the sink stalls, one more result is caught in the
// skid entry and then s_axis_tready drops until the output register drains.
// Reset clears the frame state and the receive timer, loads the link timer
// with the first link period and restores all registers to their defaults.
// The user writes registers over cfg_we/cfg_index/cfg_data only while the
// block is idle (not enforced); the first link period acts only at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rs485_frame_receiver_core
	import rsfr_pkg::*;
#(
	parameter int MAX_FRAME        = 200,
	parameter int KEEPALIVE_RELOAD = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// rx_byte [7:0]
	input  wire logic [7:0]            s_axis_tdata,
	// req_type [0]
	input  wire logic                  s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// echo_byte [7:0], byte_position [15:8], byte_outcome [17:16],
	// frame_length [25:18], rx_timeout_hit [26], disconnect_notice [27]
	output logic [TDATA_W-1:0]         m_axis_tdata
);

	cfg_t cfg;
	res_t res;
	res_t out_res;
	logic accept;

	assign accept = s_axis_tvalid && s_axis_tready;

	rsfr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rsfr_frame #(
		.MAX_FRAME        (MAX_FRAME),
		.KEEPALIVE_RELOAD (KEEPALIVE_RELOAD)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.req_accept (accept),
		.req_type   (s_axis_tuser),
		.rx_byte    (s_axis_tdata),
		.res        (res)
	);

	rsfr_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_res    (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = TDATA_W'(out_res);

endmodule

`default_nettype wire

// ===== rtl/rsfr_checker.sv =====
// ----------------------------------------------------------------------------
// RS485 frame receiver port checker
// Checks properties of the result stream seen on the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfr_checker
	import rsfr_pkg::*;
#(
	parameter int MAX_FRAME = 200
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_axis_tvalid,
	input wire logic               s_axis_tready,
	input wire logic               m_axis_tvalid,
	input wire logic               m_axis_tready,
	input wire logic [TDATA_W-1:0] m_axis_tdata
);

	logic [7:0] position;
	logic [1:0] outcome;
	logic [7:0] length;
	logic       flags;

	assign position = m_axis_tdata[15:8];
	assign outcome  = m_axis_tdata[17:16];
	assign length   = m_axis_tdata[25:18];
	assign flags    = m_axis_tdata[26] || m_axis_tdata[27];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_tick_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && flags |-> m_axis_tdata[17:0] == '0 && length == '0)
		else $error("tick result carries byte fields");

	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (outcome == OUT_FORWARDED || outcome == OUT_SUPPRESSED)
			|-> length > 8'd6 && length == position + 8'd1)
		else $error("completed frame length does not match position");

	a_overlong: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && outcome == OUT_OVERLONG |-> position == 8'(MAX_FRAME - 1))
		else $error("overlong frame discarded at the wrong position");

	a_ready_skid: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && m_axis_tvalid && !m_axis_tready
			|=> !s_axis_tready || m_axis_tvalid)
		else $error("accepted result lost while output stalled");

endmodule

bind rs485_frame_receiver_core rsfr_checker #(.MAX_FRAME(MAX_FRAME)) u_rsfr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RS485 frame receiver testbench
// Sends a mix of received bytes and timebase ticks into the frame receiver:
// a short directed opening, then well-formed frames, keep-alives, broken and
// overlong frames, noise and tick runs under several register settings. Each
// request is predicted in the testbench and every result is checked field by
// field, with random gaps on the request side and stalls on the result side.
// ----------------------------------------------------------------------------

module tb;
	import rsfr_pkg::*;

	localparam int MAX_FRAME  = 200;
	localparam int KA_RELOAD  = 6;
	localparam int CLK_HALF   = 6;
	localparam int CYCLE_CAP  = 600000;
	localparam int LONG_HOLD  = 300;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
	} rx_req_t;

	typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_HALF} sink_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [TDATA_W-1:0]    m_tdata;

	rx_req_t req_q[$];
	res_t    outcome_q[$];

	logic [16:0] reg_shadow [8];
	logic [16:0] cfg_plan [8];

	logic [7:0]  pos_next = '0;
	logic [1:0]  head_seen = '0;
	logic [2:0]  ka_seen = '0;
	logic [7:0]  last_byte = '0;
	logic [16:0] rx_left = '0;
	logic        rx_armed = 1'b0;
	logic [16:0] link_left = FIRST_LINK_RST;
	int          ka_credit = 0;

	int err_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int results_seen = 0;
	int next_hold = 400;
	int hold_left = 0;
	int mode_left = 0;
	sink_mode_t sink_mode = SINK_OPEN;
	int cycles = 0;

	rs485_frame_receiver_core #(
		.MAX_FRAME(MAX_FRAME),
		.KEEPALIVE_RELOAD(KA_RELOAD)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_tready),
		.s_axis_tdata(s_tdata),
		.s_axis_tuser(s_tuser),
		.m_axis_tvalid(m_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata(m_tdata)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic res_t frame_outcome(input logic kind, input logic [7:0] b);
		res_t       r;
		logic [8:0] cnt;
		logic [7:0] pos;
		r = '0;
		if (kind == REQ_BYTE) begin
			pos = pos_next;
			cnt = {1'b0, pos} + 9'd1;
			if (pos == 8'd0) begin
				rx_left = reg_shadow[REG_RX_TIMEOUT];
				rx_armed = 1'b1;
				link_left = reg_shadow[REG_LINK_HOLD];
				head_seen[0] = (b == reg_shadow[REG_HEAD_FIRST][7:0]);
			end else if (pos == 8'd1) begin
				head_seen[1] = (b == reg_shadow[REG_HEAD_SECOND][7:0]);
			end else if (pos == 8'd2) begin
				ka_seen[0] = (b == KA_C);
			end else if (pos == 8'd3) begin
				ka_seen[1] = (b == KA_N);
			end else if (pos == 8'd4) begin
				ka_seen[2] = (b == KA_T);
			end
			r.byte_outcome = OUT_STORED;
			if (cnt >= MAX_FRAME) begin
				cnt = '0;
				rx_armed = 1'b0;
				link_left = reg_shadow[REG_LINK_HOLD];
				r.byte_outcome = OUT_OVERLONG;
			end else if (cnt > 9'd6 && head_seen == 2'b11 &&
					last_byte == reg_shadow[REG_TAIL_FIRST][7:0] &&
					b == reg_shadow[REG_TAIL_SECOND][7:0]) begin
				link_left = reg_shadow[REG_LINK_HOLD];
				rx_armed = 1'b0;
				r.frame_length = cnt[7:0];
				r.byte_outcome = OUT_FORWARDED;
				if (ka_seen == 3'b111) begin
					if (ka_credit < 0) begin
						ka_credit = KA_RELOAD;
					end else begin
						ka_credit--;
						r.byte_outcome = OUT_SUPPRESSED;
					end
				end
				cnt = '0;
			end
			pos_next = cnt[7:0];
			last_byte = b;
			r.echo_byte = b;
			r.byte_position = pos;
		end else begin
			if (rx_armed) begin
				if (rx_left != '0)
					rx_left--;
				if (rx_left == '0) begin
					pos_next = '0;
					rx_armed = 1'b0;
					r.rx_timeout_hit = 1'b1;
				end
			end
			if (link_left != '0)
				link_left--;
			if (link_left == '0) begin
				ka_credit = 0;
				link_left = reg_shadow[REG_RECONNECT];
				r.disconnect_notice = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic push_byte(input logic [7:0] b);
		req_q.push_back('{kind: REQ_BYTE, data: b});
	endtask

	task automatic push_ticks(input int n);
		int k;
		for (k = 0; k < n; k++)
			req_q.push_back('{kind: REQ_TICK, data: 8'($urandom_range(0, 255))});
	endtask

	task automatic push_frame(input int len, input bit keepalive, input bit bad_head,
			input bit bad_tail);
		int         k;
		logic [7:0] b;
		for (k = 0; k < len; k++) begin
			b = 8'($urandom_range(0, 255));
			if (k == 0)
				b = bad_head ? ~reg_shadow[REG_HEAD_FIRST][7:0] : reg_shadow[REG_HEAD_FIRST][7:0];
			else if (k == 1)
				b = reg_shadow[REG_HEAD_SECOND][7:0];
			else if (keepalive && k == 2)
				b = KA_C;
			else if (keepalive && k == 3)
				b = KA_N;
			else if (keepalive && k == 4)
				b = KA_T;
			else if (k == len - 2)
				b = reg_shadow[REG_TAIL_FIRST][7:0];
			else if (k == len - 1)
				b = bad_tail ? ~reg_shadow[REG_TAIL_SECOND][7:0] :
					reg_shadow[REG_TAIL_SECOND][7:0];
			push_byte(b);
			if ($urandom_range(0, 9) == 0)
				push_ticks($urandom_range(1, 2));
		end
	endtask

	task automatic gen_traffic(input int n_items);
		int start;
		int pick;
		int k;
		logic [7:0] b;
		start = req_q.size();
		while (req_q.size() - start < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 42) begin
				push_frame($urandom_range(7, 24), $urandom_range(0, 3) == 0, 1'b0, 1'b0);
			end else if (pick < 62) begin
				push_frame($urandom_range(7, 12), 1'b1, 1'b0, 1'b0);
			end else if (pick < 77) begin
				push_ticks($urandom_range(0, 4) == 0 ? $urandom_range(20, 70) :
					$urandom_range(1, 12));
			end else if (pick < 87) begin
				case ($urandom_range(0, 2))
					0: push_frame($urandom_range(7, 16), $urandom_range(0, 1), 1'b1, 1'b0);
					1: push_frame($urandom_range(7, 16), $urandom_range(0, 1), 1'b0, 1'b1);
					default: begin
						push_frame($urandom_range(2, 6), 1'b0, 1'b0, 1'b0);
						push_ticks($urandom_range(1, 40));
					end
				endcase
			end else if (pick < 98) begin
				for (k = 0; k < $urandom_range(1, 6); k++) begin
					case ($urandom_range(0, 5))
						0: b = reg_shadow[REG_HEAD_FIRST][7:0];
						1: b = reg_shadow[REG_TAIL_FIRST][7:0];
						2: b = reg_shadow[REG_TAIL_SECOND][7:0];
						default: b = 8'($urandom_range(0, 255));
					endcase
					push_byte(b);
				end
			end else begin
				push_frame($urandom_range(199, 215), 1'b0, 1'b0, $urandom_range(0, 1));
			end
		end
	endtask

	task automatic apply_cfg();
		int i;
		for (i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= cfg_plan[i];
			reg_shadow[i] = (i >= REG_HEAD_FIRST) ? {9'd0, cfg_plan[i][7:0]} : cfg_plan[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (req_q.size() != 0 || outcome_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk) begin : drive_proc
		logic take;
		take = s_tvalid && s_tready;
		if (take) begin
			outcome_q.push_back(frame_outcome(req_q[0].kind, req_q[0].data));
			void'(req_q.pop_front());
		end
		if (s_tvalid && !take) begin
			s_tvalid <= 1'b1;
		end else if (gap_left > 0) begin
			gap_left--;
			s_tvalid <= 1'b0;
		end else if (arst_n && req_q.size() > 0) begin
			s_tvalid <= 1'b1;
			s_tdata <= req_q[0].data;
			s_tuser <= req_q[0].kind;
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 :
					($urandom_range(0, 9) == 0 ? $urandom_range(10, 25) : $urandom_range(1, 6));
			end else begin
				burst_left--;
			end
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	always @(posedge clk) begin : sink_proc
		res_t got;
		res_t want;
		logic rdy;
		if (m_tvalid && m_tready) begin
			got = res_t'(m_tdata[RES_W-1:0]);
			results_seen++;
			if (outcome_q.size() == 0) begin
				$error("result with no pending request: %h", got);
				err_count++;
			end else begin
				want = outcome_q.pop_front();
				check_field("echo_byte", want.echo_byte, got.echo_byte);
				check_field("byte_position", want.byte_position, got.byte_position);
				check_field("byte_outcome", want.byte_outcome, got.byte_outcome);
				check_field("frame_length", want.frame_length, got.frame_length);
				check_field("rx_timeout_hit", want.rx_timeout_hit, got.rx_timeout_hit);
				check_field("disconnect_notice", want.disconnect_notice,
					got.disconnect_notice);
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (results_seen >= next_hold) begin
			hold_left = LONG_HOLD;
			next_hold += 700;
			rdy = 1'b0;
		end else begin
			if (mode_left == 0) begin
				mode_left = $urandom_range(8, 64);
				sink_mode = sink_mode_t'($urandom_range(0, 3));
			end else begin
				mode_left--;
			end
			case (sink_mode)
				SINK_OPEN:  rdy = 1'b1;
				SINK_LIGHT: rdy = ($urandom_range(0, 3) != 0);
				SINK_HEAVY: rdy = ($urandom_range(0, 3) == 0);
				default:    rdy = $urandom_range(0, 1);
			endcase
		end
		m_tready <= arst_n && rdy;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stim_proc
		int ph;
		reg_shadow[REG_RX_TIMEOUT] = RX_TIMEOUT_RST;
		reg_shadow[REG_LINK_HOLD] = LINK_HOLD_RST;
		reg_shadow[REG_RECONNECT] = RECONNECT_RST;
		reg_shadow[REG_FIRST_LINK] = FIRST_LINK_RST;
		reg_shadow[REG_HEAD_FIRST] = HEAD_FIRST_RST;
		reg_shadow[REG_HEAD_SECOND] = HEAD_SECOND_RST;
		reg_shadow[REG_TAIL_FIRST] = TAIL_FIRST_RST;
		reg_shadow[REG_TAIL_SECOND] = TAIL_SECOND_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Opening: plain frame, keep-alive suppressed then forwarded, byte extremes.
		push_ticks(1);
		push_frame(7, 1'b0, 1'b0, 1'b0);
		push_frame(7, 1'b1, 1'b0, 1'b0);
		push_frame(7, 1'b1, 1'b0, 1'b0);
		push_byte(8'hff);
		push_byte(8'h00);
		push_ticks(1);
		gen_traffic(230);
		drain();

		cfg_plan = '{17'd1, 17'd1, 17'd1, 17'd1, 17'h00, 17'hff, 17'hff, 17'h00};
		apply_cfg();
		gen_traffic(260);
		drain();

		cfg_plan = '{17'h1ffff, 17'h1ffff, 17'h1ffff, 17'h1ffff,
			17'hff, 17'h00, 17'h00, 17'hff};
		apply_cfg();
		push_frame(200, 1'b0, 1'b0, 1'b0);
		push_frame(199, 1'b0, 1'b0, 1'b0);
		gen_traffic(150);
		drain();

		for (ph = 0; ph < 4; ph++) begin
			cfg_plan[REG_RX_TIMEOUT] = 17'($urandom_range(1, 30));
			cfg_plan[REG_LINK_HOLD] = 17'($urandom_range(1, 60));
			cfg_plan[REG_RECONNECT] = 17'($urandom_range(1, 60));
			cfg_plan[REG_FIRST_LINK] = 17'($urandom_range(1, 131071));
			cfg_plan[REG_HEAD_FIRST] = 17'($urandom_range(0, 255));
			cfg_plan[REG_HEAD_SECOND] = 17'($urandom_range(0, 255));
			cfg_plan[REG_TAIL_FIRST] = 17'($urandom_range(0, 255));
			cfg_plan[REG_TAIL_SECOND] = ($urandom_range(0, 3) == 0) ?
				cfg_plan[REG_TAIL_FIRST] : 17'($urandom_range(0, 255));
			apply_cfg();
			gen_traffic(180);
			drain();
		end

		repeat (16) @(posedge clk);
		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== rs485_frame_receiver_core.f =====
rtl/rsfr_pkg.sv
rtl/rsfr_cfg.sv
rtl/rsfr_frame.sv
rtl/rsfr_skid.sv
rtl/rs485_frame_receiver_core.sv
rtl/rsfr_checker.sv
dv/tb.sv
